### rtl/trd_pkg.sv
`default_nettype none
package trd_pkg;

  localparam logic [6:0] HDR_COUNT_MASK = 7'h7F;
  localparam int unsigned HDR_REPEAT_BIT = 7;
  localparam int unsigned BITS_PER_BYTE = 8;

  localparam logic [2:0] BPP_RESET = 3'd3;
  localparam logic [2:0] BPP_MIN = 3'd2;
  localparam logic [2:0] BPP_MAX = 3'd4;

  typedef enum logic {
    REG_BYTES_PER_PIXEL = 1'b0,
    REG_IMAGE_PIXEL_COUNT = 1'b1
  } trd_reg_idx_t;

  typedef struct packed {
    logic [31:0] pixel_value;
    logic [7:0]  run_length;
    logic        image_done;
  } trd_result_t;

endpackage
`default_nettype wire

### rtl/trd_out_buf.sv
`default_nettype none
module trd_out_buf (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       push,
  input  wire trd_pkg::trd_result_t push_data,
  output logic                      full,
  output logic                      out_valid,
  input  wire                       out_ready,
  output trd_pkg::trd_result_t      out_data
);
  import trd_pkg::*;

  // two-entry skid: head feeds the port, tail catches a result during a stall
  logic        head_valid_r;
  logic        tail_valid_r;
  trd_result_t head_r;
  trd_result_t tail_r;
  logic        pop;

  assign pop       = head_valid_r && out_ready;
  assign full      = tail_valid_r;
  assign out_valid = head_valid_r;
  assign out_data  = head_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_valid_r <= 1'b0;
      tail_valid_r <= 1'b0;
    end else if (pop) begin
      if (tail_valid_r) begin
        head_r       <= tail_r;
        tail_valid_r <= push;
        if (push) begin
          tail_r <= push_data;
        end
      end else begin
        head_valid_r <= push;
        if (push) begin
          head_r <= push_data;
        end
      end
    end else if (push) begin
      if (!head_valid_r) begin
        head_valid_r <= 1'b1;
        head_r       <= push_data;
      end else begin
        tail_valid_r <= 1'b1;
        tail_r       <= push_data;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/tga_rle_pixel_decoder_core.sv
// A byte that completes a pixel has its result registered in the output buffer before it shows on the output.
// Throughput: one byte per cycle while the output buffer is not full; header and partial-pixel bytes give no result.
// A two-entry output buffer lets bytes keep flowing while one result waits.
// Reset (rst_n low, synchronous): decoder idle, bytes_per_pixel 3, image size 0,
// output buffer empty. Bytes are ignored until one with frame_start arrives.
`default_nettype none
module tga_rle_pixel_decoder_core (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [7:0]  in_stream_byte,
  input  wire         in_frame_start,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [31:0] out_pixel_value,
  output logic [7:0]  out_run_length,
  output logic        out_image_done,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import trd_pkg::*;

  logic [2:0]  bytes_per_pixel_r;
  logic [31:0] image_pixel_count_r;

  logic        expect_header_r, expect_header_nxt;
  logic        repeat_packet_r, repeat_packet_nxt;
  logic [7:0]  packet_pixels_left_r, packet_pixels_left_nxt;
  logic [1:0]  pixel_byte_index_r, pixel_byte_index_nxt;
  logic [31:0] pixel_accumulator_r, pixel_accumulator_nxt;
  logic [31:0] pixels_remaining_r, pixels_remaining_nxt;

  logic        hdr_c, rep_c;
  logic [7:0]  left_c;
  logic [1:0]  idx_c, idx_inc;
  logic [31:0] acc_c, acc_new, rem_c;
  logic [2:0]  eff_bpp;
  logic [7:0]  run;
  logic        emit;
  logic        accept;
  logic        buf_full;
  trd_result_t result;
  trd_result_t out_data;
  trd_reg_idx_t reg_idx;
  logic        cfg_wr;

  // configuration port
  assign pready  = 1'b1;
  assign reg_idx = trd_reg_idx_t'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    unique case (reg_idx)
      REG_BYTES_PER_PIXEL:   prdata = {29'd0, bytes_per_pixel_r};
      REG_IMAGE_PIXEL_COUNT: prdata = image_pixel_count_r;
      default:               prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_per_pixel_r   <= BPP_RESET;
      image_pixel_count_r <= 32'd0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_BYTES_PER_PIXEL:   bytes_per_pixel_r   <= pwdata[2:0];
        REG_IMAGE_PIXEL_COUNT: image_pixel_count_r <= pwdata;
        default: ;
      endcase
    end
  end

  assign eff_bpp = (bytes_per_pixel_r < BPP_MIN) ? BPP_MIN :
                   (bytes_per_pixel_r > BPP_MAX) ? BPP_MAX : bytes_per_pixel_r;

  assign in_ready = !buf_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    // frame_start clears the decoder before the byte is looked at
    hdr_c  = in_frame_start ? 1'b1 : expect_header_r;
    rep_c  = in_frame_start ? 1'b0 : repeat_packet_r;
    left_c = in_frame_start ? 8'd0 : packet_pixels_left_r;
    idx_c  = in_frame_start ? 2'd0 : pixel_byte_index_r;
    acc_c  = in_frame_start ? 32'd0 : pixel_accumulator_r;
    rem_c  = in_frame_start ? image_pixel_count_r : pixels_remaining_r;

    expect_header_nxt      = hdr_c;
    repeat_packet_nxt      = rep_c;
    packet_pixels_left_nxt = left_c;
    pixel_byte_index_nxt   = idx_c;
    pixel_accumulator_nxt  = acc_c;
    pixels_remaining_nxt   = rem_c;
    emit                   = 1'b0;
    run                    = 8'd1;
    idx_inc                = idx_c + 2'd1;
    acc_new                = acc_c | ({24'd0, in_stream_byte} << {idx_c, 3'b000});

    if (rem_c != 32'd0) begin
      if (hdr_c) begin
        packet_pixels_left_nxt = {1'b0, in_stream_byte[6:0] & HDR_COUNT_MASK} + 8'd1;
        repeat_packet_nxt      = in_stream_byte[HDR_REPEAT_BIT];
        expect_header_nxt      = 1'b0;
        pixel_byte_index_nxt   = 2'd0;
        pixel_accumulator_nxt  = 32'd0;
      end else if (idx_inc != 2'd0 && {1'b0, idx_inc} < eff_bpp) begin
        pixel_byte_index_nxt  = idx_inc;
        pixel_accumulator_nxt = acc_new;
      end else begin
        emit = 1'b1;
        if (rep_c) begin
          // run never exceeds 128, so a clipped run fits in 8 bits
          run = ({24'd0, left_c} > rem_c) ? rem_c[7:0] : left_c;
          packet_pixels_left_nxt = 8'd0;
        end else begin
          run = 8'd1;
          packet_pixels_left_nxt = left_c - 8'd1;
        end
        pixels_remaining_nxt  = rem_c - {24'd0, run};
        pixel_byte_index_nxt  = 2'd0;
        pixel_accumulator_nxt = 32'd0;
        expect_header_nxt     = (packet_pixels_left_nxt == 8'd0);
      end
    end

    result.pixel_value = acc_new;
    result.run_length  = run;
    result.image_done  = (pixels_remaining_nxt == 32'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expect_header_r      <= 1'b1;
      repeat_packet_r      <= 1'b0;
      packet_pixels_left_r <= 8'd0;
      pixel_byte_index_r   <= 2'd0;
      pixel_accumulator_r  <= 32'd0;
      pixels_remaining_r   <= 32'd0;
    end else if (accept) begin
      expect_header_r      <= expect_header_nxt;
      repeat_packet_r      <= repeat_packet_nxt;
      packet_pixels_left_r <= packet_pixels_left_nxt;
      pixel_byte_index_r   <= pixel_byte_index_nxt;
      pixel_accumulator_r  <= pixel_accumulator_nxt;
      pixels_remaining_r   <= pixels_remaining_nxt;
    end
  end

  trd_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept && emit),
    .push_data (result),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign out_pixel_value = out_data.pixel_value;
  assign out_run_length  = out_data.run_length;
  assign out_image_done  = out_data.image_done;

endmodule
`default_nettype wire

### rtl/trd_checker.sv
`default_nettype none
module trd_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_valid,
  input wire        in_ready,
  input wire        in_frame_start,
  input wire        out_valid,
  input wire        out_ready,
  input wire [31:0] out_pixel_value,
  input wire [7:0]  out_run_length,
  input wire        out_image_done
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel_value)
      && $stable(out_run_length) && $stable(out_image_done))
    else $error("result changed while stalled");

  a_run_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_run_length != 8'd0 && out_run_length <= 8'd128)
    else $error("run length out of range");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result present right after reset");

  // a frame start byte is always a header or ignored: it never makes a result
  a_start_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_frame_start && !out_valid |=> !out_valid)
    else $error("result from a frame start byte");

endmodule

bind tga_rle_pixel_decoder_core trd_checker u_trd_checker (.*);
`default_nettype wire
